// ===== design/rse_pkg.sv =====
`default_nettype none

package rse_pkg;

   localparam int SYMBOL_BITS = 8;
   localparam int MAX_PARITY  = 16;
   localparam int CSR_W       = 5;

   // parity count width (holds MAX_PARITY) and parity register index width
   localparam int CNT_W = $clog2(MAX_PARITY + 1);
   localparam int IDX_W = $clog2(MAX_PARITY);
   localparam int SUM_W = ((SYMBOL_BITS > CNT_W) ? SYMBOL_BITS : CNT_W) + 1;
   localparam int FIELD_MAX = (1 << SYMBOL_BITS) - 1;

   typedef logic [SYMBOL_BITS-1:0] sym_type;
   typedef sym_type [MAX_PARITY:0] gen_type;
   typedef gen_type [MAX_PARITY-1:0] gen_tab_type;

   typedef struct packed {
      logic [7:0] message_symbol;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [7:0] code_symbol;
      logic       is_parity;
      logic       codeword_end;
      logic       overlength;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] peff;
      gen_type          gen;
      logic             clear;
   } cfg_type;

   function automatic int field_poly(input int bits);
      int poly;
      case (bits)
         3:       poly = 'h00B;
         4:       poly = 'h019;
         5:       poly = 'h025;
         6:       poly = 'h043;
         7:       poly = 'h083;
         8:       poly = 'h171;
         9:       poly = 'h211;
         10:      poly = 'h409;
         11:      poly = 'h805;
         12:      poly = 'h1099;
         default: poly = 'h171;
      endcase
      return poly;
   endfunction

   localparam sym_type POLY_LOW = SYMBOL_BITS'(field_poly(SYMBOL_BITS));

   function automatic sym_type gf_mul(input sym_type a, input sym_type b);
      sym_type acc;
      sym_type sh;
      acc = '0;
      sh  = a;
      for (int k = 0; k < SYMBOL_BITS; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         sh = {sh[SYMBOL_BITS-2:0], 1'b0} ^ (sh[SYMBOL_BITS-1] ? POLY_LOW : '0);
      end
      return acc;
   endfunction

   // generator coefficients for every parity count, entry p-1 holds prod (x + alpha^i)
   function automatic gen_tab_type build_gen_table();
      gen_tab_type tab;
      gen_type     g;
      sym_type     root;
      tab = '0;
      for (int p = 1; p <= MAX_PARITY; p++) begin
         g    = '0;
         g[0] = SYMBOL_BITS'(1);
         root = SYMBOL_BITS'(1);
         for (int i = 1; i <= p; i++) begin
            root = gf_mul(root, SYMBOL_BITS'(2));
            for (int j = i; j > 0; j--) begin
               g[j] = g[j-1] ^ gf_mul(g[j], root);
            end
            g[0] = gf_mul(g[0], root);
         end
         tab[p-1] = g;
      end
      return tab;
   endfunction

   localparam gen_tab_type GEN_TABLE = build_gen_table();

endpackage

`default_nettype wire

// ===== design/reed_solomon_systematic_encoder_top.sv =====
// Systematic Reed-Solomon encoder over GF(2^8), field polynomial x^8+x^6+x^5+x^4+1.
// req_* channel: one message symbol per transaction, highest degree first;
//   block_end marks the last symbol of a block.
// rsp_* channel: every message symbol is echoed, and after the last one the
//   parity symbols follow, highest degree first, codeword_end on the final one.
//   overlength is set once message plus parity exceeds 255 symbols.
// csr_*: write the parity count (0 acts as 1, above 16 as 16). A write abandons
//   any partial block; write only while the block is idle.
// Path: a request is registered in the input queue and then in the output register before its echo.
// Throughput: one transaction per cycle on each side while rsp_stall is low; no
//   request is taken while parity drains, so a block of n symbols occupies the
//   output for its n symbols and then its parity symbols, the single result register being the limit.
// Reset: parity count 16, parity register cleared; nothing is stalled after reset.
// When rsp_stall is high the output holds; the 2-entry input queue fills and
//   then req_stall rises.
`default_nettype none

module reed_solomon_systematic_encoder_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire rse_pkg::req_type            req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output rse_pkg::rsp_type                 rsp_payload,
   input  wire logic                        csr_write_enable,
   input  wire logic [rse_pkg::CSR_W-1:0]   csr_write_data
);
   import rse_pkg::*;

   logic [CNT_W-1:0] peff_ff, peff_in;
   gen_type          gen_ff;
   cfg_type          cfg;
   logic             q_valid;
   req_type          q_data;
   logic             q_pop;

   always_comb begin
      if (int'(csr_write_data) > MAX_PARITY) begin
         peff_in = CNT_W'(MAX_PARITY);
      end else if (csr_write_data == '0) begin
         peff_in = CNT_W'(1);
      end else begin
         peff_in = CNT_W'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peff_ff <= CNT_W'(MAX_PARITY);
         gen_ff  <= GEN_TABLE[MAX_PARITY-1];
      end else if (csr_write_enable) begin
         peff_ff <= peff_in;
         gen_ff  <= GEN_TABLE[IDX_W'(peff_in - CNT_W'(1))];
      end
   end

   assign cfg.peff  = peff_ff;
   assign cfg.gen   = gen_ff;
   assign cfg.clear = csr_write_enable;

   rse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop)
   );

   rse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== design/rse_front.sv =====
`default_nettype none

module rse_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rse_pkg::req_type req_payload,
   output logic                  q_valid,
   output rse_pkg::req_type      q_data,
   input  wire logic             q_pop
);
   import rse_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

`default_nettype wire

// ===== design/rse_back.sv =====
`default_nettype none

module rse_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rse_pkg::cfg_type cfg,
   input  wire logic             q_valid,
   input  wire rse_pkg::req_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rse_pkg::rsp_type      rsp_payload
);
   import rse_pkg::*;

   sym_type          par_ff  [MAX_PARITY];
   sym_type          par_in  [MAX_PARITY];
   logic [SYMBOL_BITS-1:0] cnt_ff, cnt_in;
   logic             over_ff, over_in;
   logic             emit_ff, emit_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic [IDX_W-1:0] tap_idx;
   sym_type          sym;
   sym_type          fb;
   logic [SYMBOL_BITS-1:0] cnt_next;
   logic             over_now;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign q_pop       = out_free && !emit_ff && !cfg.clear;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign tap_idx  = IDX_W'(cfg.peff - CNT_W'(1));
   assign sym      = SYMBOL_BITS'(q_data.message_symbol);
   assign fb       = sym ^ par_ff[tap_idx];
   assign cnt_next = (cnt_ff == SYMBOL_BITS'(FIELD_MAX)) ? cnt_ff : cnt_ff + SYMBOL_BITS'(1);
   assign over_now = (SUM_W'(cnt_next) + SUM_W'(cfg.peff)) > SUM_W'(FIELD_MAX);

   always_comb begin
      par_in       = par_ff;
      cnt_in       = cnt_ff;
      over_in      = over_ff;
      emit_in      = emit_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cfg.clear) begin
         for (int j = 0; j < MAX_PARITY; j++) begin
            par_in[j] = '0;
         end
         cnt_in       = '0;
         emit_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end else if (out_free) begin
         if (emit_ff) begin
            // parity drains from the top tap; shifting up leaves zeros behind
            rsp_in.code_symbol  = 8'(par_ff[tap_idx]);
            rsp_in.is_parity    = 1'b1;
            rsp_in.codeword_end = (left_ff == CNT_W'(1));
            rsp_in.overlength   = over_ff;
            rsp_valid_in        = 1'b1;
            for (int j = 1; j < MAX_PARITY; j++) begin
               par_in[j] = par_ff[j-1];
            end
            par_in[0] = '0;
            left_in   = left_ff - CNT_W'(1);
            emit_in   = (left_ff != CNT_W'(1));
         end else if (q_valid) begin
            for (int j = 1; j < MAX_PARITY; j++) begin
               if (CNT_W'(j) < cfg.peff) begin
                  par_in[j] = par_ff[j-1] ^ gf_mul(cfg.gen[j], fb);
               end
            end
            par_in[0]           = gf_mul(cfg.gen[0], fb);
            rsp_in.code_symbol  = 8'(sym);
            rsp_in.is_parity    = 1'b0;
            rsp_in.codeword_end = 1'b0;
            rsp_in.overlength   = over_now;
            rsp_valid_in        = 1'b1;
            over_in             = over_now;
            if (q_data.block_end) begin
               emit_in = 1'b1;
               left_in = cfg.peff;
               cnt_in  = '0;
            end else begin
               cnt_in = cnt_next;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_PARITY; j++) begin
            par_ff[j] <= '0;
         end
         cnt_ff       <= '0;
         over_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         par_ff       <= par_in;
         cnt_ff       <= cnt_in;
         over_ff      <= over_in;
         emit_ff      <= emit_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire
